### rtl/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg
// Shared types, codes and constants for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmg_pkg;

  // field widths
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned PROD_W  = 2 * ENTRY_W;
  localparam int unsigned VALUE_W = 40;

  // cycles from the last issued operand pair to the end of its result strobe
  localparam int unsigned MAC_LAT = 3;

  // reset value of each dimension register
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // command codes
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_GRAM_MODE = 2'd3
  } reg_e;

  // control tag that travels with each operand pair through the mac pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mmg_tag_t;

  // clamp a dimension register to the range 1 .. max_dim
  function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] raw,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (raw > max_dim) begin
      res = max_dim;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

### rtl/matrix_multiply_gram.sv
// ----------------------------------------------------------------------------
// matrix_multiply_gram
// Fixed-point Q7.8 matrix multiply C = A*B, or C = A*A^T in Gram mode.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+----------------------
//  command   | operation_i row_index_i col_index_i entry_value_i | start & !busy
//  result    | out_row_o out_col_o out_value_o last_o         | result_valid_o, 1 cycle
//  config    | psel penable pwrite paddr pwdata prdata pready | apb write, no wait
//
//  a load or ignored command never raises busy; loads stream back to back
//  a run keeps busy high while it issues all m*c*n terms (c = cols_b, or rows_a
//  in gram mode) and while the mac drains; single shared multiplier: one product per cycle
//  one result per element comes while busy; the receiver cannot stall
//  reset clears both stores at once through per-entry valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_gram
  import mmg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation_i,
  input  logic [IDX_W-1:0]          row_index_i,
  input  logic [IDX_W-1:0]          col_index_i,
  input  logic signed [ENTRY_W-1:0] entry_value_i,
  output logic                      result_valid_o,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      last_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  logic [DIM_W-1:0] rows_a_q;
  logic [DIM_W-1:0] inner_dim_q;
  logic [DIM_W-1:0] cols_b_q;
  logic             gram_mode_q;
  logic             cfg_we;
  reg_e             cfg_idx;
  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_n;
  logic [DIM_W-1:0] dim_p;

  logic                      we_a;
  logic                      we_b;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr_a0;
  logic [AW-1:0]             raddr_a1;
  logic [AW-1:0]             raddr_b;
  logic signed [ENTRY_W-1:0] op_a;
  logic signed [ENTRY_W-1:0] op_b;
  mmg_tag_t                  tag;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
      gram_mode_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS_A:    rows_a_q    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_q    <= pwdata[DIM_W-1:0];
        REG_GRAM_MODE: gram_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_ROWS_A:    prdata = 32'(rows_a_q);
      REG_INNER_DIM: prdata = 32'(inner_dim_q);
      REG_COLS_B:    prdata = 32'(cols_b_q);
      REG_GRAM_MODE: prdata = 32'(gram_mode_q);
      default:       prdata = '0;
    endcase
  end

  // effective dimensions
  assign dim_m = dim_sat(rows_a_q, DIM_W'(MAX_DIM));
  assign dim_n = dim_sat(inner_dim_q, DIM_W'(MAX_DIM));
  assign dim_p = dim_sat(cols_b_q, DIM_W'(MAX_DIM));

  // command decode and sequencer
  mmg_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .op_i       (op_e'(operation_i)),
    .row_i      (row_index_i),
    .col_i      (col_index_i),
    .dim_m_i    (dim_m),
    .dim_n_i    (dim_n),
    .dim_p_i    (dim_p),
    .gram_i     (gram_mode_q),
    .busy       (busy),
    .we_a_o     (we_a),
    .we_b_o     (we_b),
    .waddr_o    (waddr),
    .raddr_a0_o (raddr_a0),
    .raddr_a1_o (raddr_a1),
    .raddr_b_o  (raddr_b),
    .tag_o      (tag)
  );

  // matrix stores
  mmg_stores #(
    .MAX_DIM(MAX_DIM)
  ) u_stores (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gram_i     (gram_mode_q),
    .we_a_i     (we_a),
    .we_b_i     (we_b),
    .waddr_i    (waddr),
    .wdata_i    (entry_value_i),
    .raddr_a0_i (raddr_a0),
    .raddr_a1_i (raddr_a1),
    .raddr_b_i  (raddr_b),
    .op_a_o     (op_a),
    .op_b_o     (op_b)
  );

  // shared multiply-accumulate
  mmg_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (tag),
    .op_a_i         (op_a),
    .op_b_i         (op_b),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  // results only appear inside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a run");

  // the final element ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy)
    else $error("block still busy after the last element");

  // an accepted run command starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_RUN)) |=> busy)
    else $error("run transaction did not start the sequencer");

  // busy rises only on a run command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (operation_i == OP_RUN)))
    else $error("busy raised without a run transaction");
`endif

endmodule

### rtl/mmg_stores.sv
// ----------------------------------------------------------------------------
// mmg_stores
// Matrix A and B entry memories with per-entry valid bits; unwritten reads zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmg_stores
  import mmg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           gram_i,
  input  logic                           we_a_i,
  input  logic                           we_b_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr_i,
  input  logic signed [ENTRY_W-1:0]      wdata_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a0_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a1_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_b_i,
  output logic signed [ENTRY_W-1:0]      op_a_o,
  output logic signed [ENTRY_W-1:0]      op_b_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;

  logic signed [ENTRY_W-1:0] mem_a [Depth];
  logic signed [ENTRY_W-1:0] mem_b [Depth];
  logic [Depth-1:0]          vld_a_q;
  logic [Depth-1:0]          vld_b_q;

  logic signed [ENTRY_W-1:0] rd_a0_q;
  logic signed [ENTRY_W-1:0] rd_a1_q;
  logic signed [ENTRY_W-1:0] rd_b_q;
  logic                      rv_a0_q;
  logic                      rv_a1_q;
  logic                      rv_b_q;

  // memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_a_i) begin
      mem_a[waddr_i] <= wdata_i;
    end
    if (we_b_i) begin
      mem_b[waddr_i] <= wdata_i;
    end
    rd_a0_q <= mem_a[raddr_a0_i];
    rd_a1_q <= mem_a[raddr_a1_i];
    rd_b_q  <= mem_b[raddr_b_i];
  end

  // valid bits, cleared at reset so the stores read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
      rv_a0_q <= 1'b0;
      rv_a1_q <= 1'b0;
      rv_b_q  <= 1'b0;
    end else begin
      if (we_a_i) begin
        vld_a_q[waddr_i] <= 1'b1;
      end
      if (we_b_i) begin
        vld_b_q[waddr_i] <= 1'b1;
      end
      rv_a0_q <= vld_a_q[raddr_a0_i];
      rv_a1_q <= vld_a_q[raddr_a1_i];
      rv_b_q  <= vld_b_q[raddr_b_i];
    end
  end

  // mask unwritten entries, pick the second operand source
  always_comb begin
    op_a_o = rv_a0_q ? rd_a0_q : '0;
    if (gram_i) begin
      op_b_o = rv_a1_q ? rd_a1_q : '0;
    end else begin
      op_b_o = rv_b_q ? rd_b_q : '0;
    end
  end

endmodule

### rtl/mmg_mac.sv
// ----------------------------------------------------------------------------
// mmg_mac
// Shared multiply-accumulate unit: one 16x16 signed product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmg_mac
  import mmg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mmg_tag_t                  tag_i,
  input  logic signed [ENTRY_W-1:0] op_a_i,
  input  logic signed [ENTRY_W-1:0] op_b_i,
  output logic                      result_valid_o,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      last_o
);

  mmg_tag_t                  tag1_q;
  mmg_tag_t                  tag2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VALUE_W-1:0] acc_q;
  logic signed [VALUE_W-1:0] acc_d;
  logic signed [VALUE_W-1:0] prod_ext;
  logic                      out_vld_q;
  logic [IDX_W-1:0]          out_row_q;
  logic [IDX_W-1:0]          out_col_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q;

  // accumulate, restarting on the first term of each element
  assign prod_ext = VALUE_W'(prod_q);
  assign acc_d    = tag2_q.first ? prod_ext : acc_q + prod_ext;

  // tag pipeline and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q    <= '0;
      tag2_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tag1_q    <= tag_i;
      tag2_q    <= tag1_q;
      out_vld_q <= tag2_q.valid && tag2_q.last_k;
    end
  end

  // product, accumulator and result payload
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag2_q.valid && tag2_q.last_k) begin
      out_value_q <= acc_d;
      out_row_q   <= tag2_q.row;
      out_col_q   <= tag2_q.col;
      out_last_q  <= tag2_q.last_elem;
    end
  end

  assign result_valid_o = out_vld_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_value_o    = out_value_q;
  assign last_o         = out_last_q;

endmodule

### rtl/mmg_seq.sv
// ----------------------------------------------------------------------------
// mmg_seq
// Command decode and i/j/k sequencer that feeds the shared mac unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmg_seq
  import mmg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  op_e                                op_i,
  input  logic [IDX_W-1:0]                   row_i,
  input  logic [IDX_W-1:0]                   col_i,
  input  logic [DIM_W-1:0]                   dim_m_i,
  input  logic [DIM_W-1:0]                   dim_n_i,
  input  logic [DIM_W-1:0]                   dim_p_i,
  input  logic                               gram_i,
  output logic                               busy,
  output logic                               we_a_o,
  output logic                               we_b_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a0_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a1_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_b_o,
  output mmg_tag_t                           tag_o
);

  localparam int unsigned AW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned FW  = AW + IDX_W;
  localparam int unsigned CW  = $clog2(MAC_LAT);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             accept;
  logic [DIM_W-1:0] ncols;
  logic             i_end;
  logic             j_end;
  logic             k_end;

  // row-major store address
  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    logic [FW-1:0] full;
    full = FW'(r) * FW'(MAX_DIM) + FW'(c);
    return full[AW-1:0];
  endfunction

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign ncols  = gram_i ? dim_m_i : dim_p_i;

  // loads, dropped when outside the configured dimensions
  assign we_a_o  = accept && (op_i == OP_LOAD_A) &&
                   ({1'b0, row_i} < dim_m_i) && ({1'b0, col_i} < dim_n_i);
  assign we_b_o  = accept && (op_i == OP_LOAD_B) &&
                   ({1'b0, row_i} < dim_n_i) && ({1'b0, col_i} < dim_p_i);
  assign waddr_o = addr_of(row_i, col_i);

  // operand addresses for the current term
  assign raddr_a0_o = addr_of(i_q, k_q);
  assign raddr_a1_o = addr_of(j_q, k_q);
  assign raddr_b_o  = addr_of(k_q, j_q);

  assign i_end = ({1'b0, i_q} == dim_m_i - DIM_W'(1));
  assign j_end = ({1'b0, j_q} == ncols - DIM_W'(1));
  assign k_end = ({1'b0, k_q} == dim_n_i - DIM_W'(1));

  // tag for the term issued this cycle
  always_comb begin
    tag_o.valid     = (state_q == S_RUN);
    tag_o.first     = (k_q == '0);
    tag_o.last_k    = k_end;
    tag_o.last_elem = i_end && j_end;
    tag_o.row       = i_q;
    tag_o.col       = j_q;
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_RUN)) begin
          state_d = S_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      S_RUN: begin
        if (k_end) begin
          k_d = '0;
          if (j_end) begin
            j_d = '0;
            if (i_end) begin
              state_d = S_DRAIN;
              cnt_d   = '0;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (cnt_q == CW'(MAC_LAT - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### tb/sv/tb_matrix_multiply_gram.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_gram
// Self-checking testbench for the Q7.8 matrix multiplier with Gram mode.
// A directed table covers reset contents, value extremes, ignored loads,
// saturated dimensions and stale entries. Random phases then load matrices
// and run products under several idle patterns. Every result element is
// compared field by field against a local model of the stores and registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_multiply_gram;
  import mmg_pkg::*;

  localparam int unsigned MAXD           = 8;
  localparam int unsigned RAND_ITEMS     = 410;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // typed values for the directed table
  localparam logic [39:0] Q_SQ_MIN  = 40'sd1073741824;   // (-1.0 * 128)^2 in Q.16
  localparam logic [39:0] Q_MIN_MAX = -40'sd1073709056;  // most negative times most positive
  localparam logic [39:0] Q_PEAK    = 40'sd8589934592;   // eight squared minimums

  // one row of the directed table: a command or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  code;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] data;
    logic        typed;
    logic [39:0] typed_val;
  } dir_row_t;

  // one expected element of the product matrix
  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [39:0] value;
    logic               last;
  } elem_t;

  localparam dir_row_t DIRECTED [34] = '{
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, 40'd0},   // stores are zero after reset
    '{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd1,    1'b0, 40'd0},
    '{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd1,    1'b0, 40'd0},
    '{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd1,    1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd0, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_B,     3'd0, 3'd0, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_SQ_MIN},
    '{1'b0, OP_LOAD_B,     3'd0, 3'd0, 16'h7fff, 1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_MIN_MAX},
    '{1'b0, OP_LOAD_A,     3'd1, 3'd0, 16'h0005, 1'b0, 40'd0},   // row outside A, dropped
    '{1'b0, OP_LOAD_B,     3'd0, 3'd1, 16'h0007, 1'b0, 40'd0},   // column outside B, dropped
    '{1'b0, OP_NONE,       3'd7, 3'd7, 16'hffff, 1'b0, 40'd0},   // unused code, dropped
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_MIN_MAX},
    '{1'b1, REG_GRAM_MODE, 3'd0, 3'd0, 16'd1,    1'b0, 40'd0},
    '{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd8,    1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd1, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd2, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd3, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd4, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd5, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd6, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd7, 16'h8000, 1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_PEAK},   // largest magnitude
    '{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd1,    1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_SQ_MIN},
    '{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd8,    1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b1, Q_PEAK},   // stale entries return
    '{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd0,    1'b0, 40'd0},   // zero acts as one
    '{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd15,   1'b0, 40'd0},   // above max acts as max
    '{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd9,    1'b0, 40'd0},
    '{1'b1, REG_GRAM_MODE, 3'd0, 3'd0, 16'd0,    1'b0, 40'd0},
    '{1'b0, OP_LOAD_B,     3'd7, 3'd7, 16'h7fff, 1'b0, 40'd0},
    '{1'b0, OP_LOAD_A,     3'd0, 3'd7, 16'h00ff, 1'b0, 40'd0},
    '{1'b0, OP_RUN,        3'd0, 3'd0, 16'h0000, 1'b0, 40'd0}
  };

  // sender idle percentage per phase; the receiver phase has nothing to throttle
  localparam int unsigned IDLE_PCT [4] = '{0, 82, 0, 27};

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                operation_i;
  logic [IDX_W-1:0]          row_index_i;
  logic [IDX_W-1:0]          col_index_i;
  logic signed [ENTRY_W-1:0] entry_value_i;
  logic                      result_valid_o;
  logic [IDX_W-1:0]          out_row_o;
  logic [IDX_W-1:0]          out_col_o;
  logic signed [VALUE_W-1:0] out_value_o;
  logic                      last_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [3:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  // local copy of the stores and registers
  logic signed [15:0] a_mem [MAXD*MAXD];
  logic signed [15:0] b_mem [MAXD*MAXD];
  logic [3:0]         cfg_rows;
  logic [3:0]         cfg_inner;
  logic [3:0]         cfg_cols;
  logic               cfg_gram;

  elem_t       expected_elems [$];
  int unsigned idle_pct;
  int unsigned n_errors = 0;
  int unsigned n_cmds;
  int unsigned n_useful;
  int unsigned n_results = 0;
  int unsigned n_phases;
  int unsigned idle_cycles = 0;

  matrix_multiply_gram #(.MAX_DIM(MAXD)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .entry_value_i  (entry_value_i),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // effective dimension of a register value
  function automatic int unsigned clamp_dim(logic [3:0] raw);
    if (raw == 4'd0) return 1;
    if (raw > MAXD) return MAXD;
    return raw;
  endfunction

  // apply one command to the local stores; a run queues its product elements
  function automatic bit apply_command(op_e op, logic [2:0] r, logic [2:0] c,
                                       logic signed [15:0] v, bit typed,
                                       logic [39:0] typed_val);
    int unsigned        m, n, p, ncols, i, j, k;
    logic signed [39:0] acc, fa, fb;
    elem_t              e;
    bit                 took;
    m = clamp_dim(cfg_rows);
    n = clamp_dim(cfg_inner);
    p = clamp_dim(cfg_cols);
    took = 1'b0;
    case (op)
      OP_LOAD_A: begin
        if (r < m && c < n) begin
          a_mem[r*MAXD + c] = v;
          took = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (r < n && c < p) begin
          b_mem[r*MAXD + c] = v;
          took = 1'b1;
        end
      end
      OP_RUN: begin
        took = 1'b1;
        ncols = cfg_gram ? m : p;
        for (i = 0; i < m; i++) begin
          for (j = 0; j < ncols; j++) begin
            acc = '0;
            for (k = 0; k < n; k++) begin
              fa = a_mem[i*MAXD + k];
              fb = cfg_gram ? a_mem[j*MAXD + k] : b_mem[k*MAXD + j];
              acc = acc + fa * fb;
            end
            e.row   = 3'(i);
            e.col   = 3'(j);
            e.value = typed ? typed_val : acc;
            e.last  = (i == m - 1) && (j == ncols - 1);
            expected_elems.push_back(e);
          end
        end
      end
      default: ;
    endcase
    return took;
  endfunction

  // random entry value, extremes now and then
  function automatic logic [15:0] rand_entry();
    if ($urandom_range(0, 7) != 0) return 16'($urandom());
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // dimension register value at or beyond the legal edges
  function automatic logic [3:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd9;
      default: return 4'd15;
    endcase
  endfunction

  // send one command transaction, with random idle cycles before it
  task automatic issue(op_e op, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                       bit typed, logic [39:0] typed_val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    operation_i   <= op;
    row_index_i   <= r;
    col_index_i   <= c;
    entry_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_cmds++;
    if (apply_command(op, r, c, v, typed, typed_val)) n_useful++;
  endtask

  // wait until the block is idle and every expected element has arrived
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_elems.size() != 0 || busy) @(posedge clk_i);
    repeat (MAC_LAT + 2) @(posedge clk_i);
  endtask

  // apb register write: setup cycle, then access cycle
  task automatic write_reg(reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_ROWS_A:    cfg_rows  = val[3:0];
      REG_INNER_DIM: cfg_inner = val[3:0];
      REG_COLS_B:    cfg_cols  = val[3:0];
      default:       cfg_gram  = val[0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // one load, in range unless noisy; noisy ones may also be the unused code
  task automatic load_random(bit noisy);
    int unsigned m, n, p;
    op_e         op;
    logic [2:0]  r, c;
    m = clamp_dim(cfg_rows);
    n = clamp_dim(cfg_inner);
    p = clamp_dim(cfg_cols);
    if (noisy) begin
      case ($urandom_range(0, 2))
        0: op = OP_NONE;
        1: op = OP_LOAD_A;
        default: op = OP_LOAD_B;
      endcase
      r = 3'($urandom_range(0, 7));
      c = 3'($urandom_range(0, 7));
    end else if ($urandom_range(0, 4) < (cfg_gram ? 4 : 2)) begin
      op = OP_LOAD_A;
      r  = 3'($urandom_range(0, m - 1));
      c  = 3'($urandom_range(0, n - 1));
    end else begin
      op = OP_LOAD_B;
      r  = 3'($urandom_range(0, n - 1));
      c  = 3'($urandom_range(0, p - 1));
    end
    issue(op, r, c, rand_entry(), 1'b0, '0);
  endtask

  // result checker: every strobe is matched against the oldest expectation
  always @(posedge clk_i) begin
    elem_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_elems.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                 $time, out_row_o, out_col_o, out_value_o, last_o);
      end else begin
        want = expected_elems.pop_front();
        n_results++;
        if (out_row_o !== want.row) begin
          n_errors++;
          $display("%0t: out_row expected %0d got %0d", $time, want.row, out_row_o);
        end
        if (out_col_o !== want.col) begin
          n_errors++;
          $display("%0t: out_col expected %0d got %0d", $time, want.col, out_col_o);
        end
        if (out_value_o !== want.value) begin
          n_errors++;
          $display("%0t: out_value at (%0d,%0d) expected %0d got %0d",
                   $time, want.row, want.col, want.value, out_value_o);
        end
        if (last_o !== want.last) begin
          n_errors++;
          $display("%0t: last expected %0b got %0b", $time, want.last, last_o);
        end
      end
    end
  end

  // count cycles in which no transaction of any kind completes
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin : watchdog
    @(posedge clk_i);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles, %0d elements outstanding",
             $time, WATCHDOG_LIMIT, expected_elems.size());
    $display("[matrix_multiply_gram] ERROR");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    dir_row_t    drow;
    int unsigned m, n, p, cnt, i, j;
    logic [3:0]  dr, dn, dc;
    logic        dg;

    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_NONE;
    row_index_i   = '0;
    col_index_i   = '0;
    entry_value_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    foreach (a_mem[k]) a_mem[k] = '0;
    foreach (b_mem[k]) b_mem[k] = '0;
    cfg_rows  = DIM_RESET;
    cfg_inner = DIM_RESET;
    cfg_cols  = DIM_RESET;
    cfg_gram  = 1'b0;
    idle_pct  = 0;
    n_cmds    = 0;
    n_useful  = 0;
    n_phases  = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[t]) begin
      drow = DIRECTED[t];
      if (drow.is_cfg) begin
        settle();
        write_reg(reg_e'(drow.code), {16'h0000, drow.data});
      end else begin
        issue(op_e'(drow.code), drow.row, drow.col, drow.data, drow.typed, drow.typed_val);
      end
    end

    // random phases: configure, load, run
    n_useful = 0;
    while (n_cmds < RAND_ITEMS) begin
      settle();
      idle_pct = IDLE_PCT[n_phases % 4];
      case ($urandom_range(0, 7))
        0: begin
          dr = 4'd8;
          dn = 4'd8;
          dc = 4'd8;
        end
        1: begin
          dr = pick_extreme();
          dn = pick_extreme();
          dc = pick_extreme();
        end
        default: begin
          dr = 4'($urandom_range(1, 4));
          dn = 4'($urandom_range(1, 4));
          dc = 4'($urandom_range(1, 4));
        end
      endcase
      dg = ($urandom_range(0, 2) == 0);
      write_reg(REG_ROWS_A,    ($urandom() & 32'hffff_fff0) | dr);
      write_reg(REG_INNER_DIM, ($urandom() & 32'hffff_fff0) | dn);
      write_reg(REG_COLS_B,    ($urandom() & 32'hffff_fff0) | dc);
      write_reg(REG_GRAM_MODE, ($urandom() & 32'hffff_fffe) | dg);
      m = clamp_dim(cfg_rows);
      n = clamp_dim(cfg_inner);
      p = clamp_dim(cfg_cols);

      if ($urandom_range(0, 1) == 0) begin
        // full load in row-major order, with the odd stray command mixed in
        for (i = 0; i < m; i++) begin
          for (j = 0; j < n; j++) begin
            issue(OP_LOAD_A, 3'(i), 3'(j), rand_entry(), 1'b0, '0);
            if ($urandom_range(0, 7) == 0) load_random(1'b1);
          end
        end
        if (!cfg_gram || $urandom_range(0, 3) == 0) begin
          for (i = 0; i < n; i++) begin
            for (j = 0; j < p; j++) begin
              issue(OP_LOAD_B, 3'(i), 3'(j), rand_entry(), 1'b0, '0);
              if ($urandom_range(0, 7) == 0) load_random(1'b1);
            end
          end
        end
      end else begin
        // partial update on top of whatever the stores hold
        cnt = $urandom_range(1, m*n + n*p);
        repeat (cnt) load_random($urandom_range(0, 99) < 15);
      end
      issue(OP_RUN, '0, '0, rand_entry(), 1'b0, '0);

      // sometimes patch a few entries and run again straight away
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) load_random($urandom_range(0, 99) < 15);
        issue(OP_RUN, 3'($urandom()), 3'($urandom()), rand_entry(), 1'b0, '0);
      end
      n_phases++;
    end

    settle();
    repeat (MAC_LAT + 4) @(posedge clk_i);
    $display("covered %0d command transactions (%0d random ones taking effect) over %0d phases",
             n_cmds, n_useful, n_phases);
    $display("checked %0d product elements, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && expected_elems.size() == 0) begin
      $display("[matrix_multiply_gram] OK");
    end else begin
      $display("[matrix_multiply_gram] ERROR");
    end
    $finish;
  end

endmodule
